@@ sv/snc_pkg.sv @@
// Shared types and constants for the skeleton node classifier.
`timescale 1ns / 1ps
`default_nettype none

package snc_pkg;

  localparam int CFG_W = 12;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_OUTPUT_MODE  = 2'd2;

  localparam logic [1:0] MODE_RANK  = 2'd0;
  localparam logic [1:0] MODE_ROLE  = 2'd1;
  localparam logic [1:0] MODE_DEBUG = 2'd2;

  // rank labels
  localparam logic [2:0] LBL_NONE   = 3'd0;
  localparam logic [2:0] LBL_END    = 3'd1;
  localparam logic [2:0] LBL_BRANCH = 3'd2;
  localparam logic [2:0] LBL_J3     = 3'd3;
  localparam logic [2:0] LBL_J4     = 3'd4;
  localparam logic [2:0] LBL_HOLLOW = 3'd5;
  localparam logic [2:0] LBL_J3_ALT = 3'd6;
  localparam logic [2:0] LBL_SQUARE = 3'd7;

  // role labels
  localparam logic [2:0] ROLE_BG     = 3'd0;
  localparam logic [2:0] ROLE_BRANCH = 3'd1;
  localparam logic [2:0] ROLE_NODE   = 3'd2;
  localparam logic [2:0] ROLE_END    = 3'd3;

  // neighbour masks, bit7 top-left then clockwise, bit0 left
  localparam logic [7:0] NB_PLUS   = 8'b0101_0101;
  localparam logic [7:0] NB_TOP    = 8'b0100_0000;
  localparam logic [7:0] NB_LOW5   = 8'b0001_1111;
  localparam logic [7:0] NB_FORK   = 8'b1010_0100;
  localparam logic [7:0] NB_X1     = 8'b0101_0001;
  localparam logic [7:0] NB_X2     = 8'b0101_0010;
  localparam logic [7:0] NB_T      = 8'b0001_0101;
  localparam logic [7:0] NB_TGAP   = 8'b0100_1010;
  localparam logic [7:0] NB_DIAG   = 8'b1010_1010;
  localparam logic [7:0] NB_SQUARE = 8'b0001_1100;
  localparam logic [7:0] NB_ALT    = 8'b0101_1010;

  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1) + 1;

  // 3x3 window: [2:0] left column, [5:3] center, [8:6] right; bit0 of a column is the top row
  typedef struct packed {
    logic [8:0] win;
    logic       last;
  } win_item_t;

  typedef struct packed {
    logic       last;
    logic [2:0] label;
  } label_item_t;

endpackage

`default_nettype wire

@@ sv/snc_line_window.sv @@
// Raster position tracking, two-row line memory and 3x3 window assembly.
`timescale 1ns / 1ps
`default_nettype none

module snc_line_window #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [snc_pkg::CFG_W-1:0] image_width,
  input  logic [snc_pkg::CFG_W-1:0] image_height,
  input  logic                    in_valid,
  input  logic                    pixel,
  input  logic                    flush,
  output logic                    busy,
  output logic                    out_valid,
  output snc_pkg::win_item_t      out_item
);
  import snc_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic [RW-1:0] h_ext, h_p1;

  logic [CW-1:0] col, col_next, x;
  logic [RW-1:0] row, row_next, y;
  logic          ignore, wrap, v, x_last, y_end, res_valid, last, acc;

  // stage 1: memory read data in flight
  logic          p1_valid;
  logic [CW-1:0] p1_x;
  logic          p1_v, p1_x0, p1_ge1, p1_ge2, p1_res, p1_last;
  logic          p1_fwd;
  logic [1:0]    p1_fwd_data;
  logic          p1_known;
  logic [1:0]    rd_q;

  logic [1:0]    line_mem [MAX_WIDTH];
  // entries below this index have been written since reset (rows fill from index 0 up)
  logic [WW-1:0] fill;

  logic [1:0]    line, wr_data;
  logic [2:0]    cnew;
  logic [8:0]    window, window_next, ev;

  always_comb begin
    if (image_width == '0) begin
      w = WW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(image_width);
    end
    if (image_height == '0) begin
      h = HW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(image_height);
    end
  end

  assign h_ext = RW'(h);
  assign h_p1  = h_ext + RW'(1);

  always_comb begin
    ignore = flush && (row == '0) && (col == '0);
    wrap   = WW'(col) >= w;
    x      = wrap ? '0 : col;
    y      = wrap ? row + RW'(1) : row;
    v      = pixel && !flush && (y < h_ext);
    x_last = (WW'(x) + WW'(1)) >= w;
    y_end  = y >= h_p1;
    if (x == '0) begin
      res_valid = (y >= RW'(2)) && (y <= h_p1);
    end else begin
      res_valid = (y >= RW'(1)) && (y <= h_ext);
    end
    last = (x == '0) && (y == h_p1);
    acc  = in_valid && !ignore;
    priority if (y_end) begin
      col_next = '0;
      row_next = '0;
    end else if (x_last) begin
      col_next = '0;
      row_next = y + RW'(1);
    end else begin
      col_next = x + CW'(1);
      row_next = y;
    end
  end

  // line entry: bit0 row above, bit1 two rows above
  always_comb begin
    line        = p1_fwd ? p1_fwd_data : (p1_known ? rd_q : 2'b00);
    cnew        = {p1_v, p1_ge1 & line[0], p1_ge2 & line[1]};
    wr_data     = {line[0], p1_v};
    window_next = p1_x0 ? {cnew, 6'b0} : {cnew, window[8:3]};
    ev          = p1_x0 ? {3'b0, window[8:3]} : window_next;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_q <= line_mem[x];
    end
    if (p1_valid) begin
      line_mem[p1_x] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      p1_valid  <= 1'b0;
      out_valid <= 1'b0;
      window    <= '0;
      fill      <= '0;
    end else begin
      if (acc) begin
        col <= col_next;
        row <= row_next;
      end
      p1_valid  <= acc;
      out_valid <= p1_valid && p1_res;
      if (p1_valid) begin
        window <= window_next;
        if (WW'(p1_x) >= fill) begin
          fill <= WW'(p1_x) + WW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p1_x    <= x;
      p1_v    <= v;
      p1_x0   <= (x == '0);
      p1_ge1  <= (y >= RW'(1));
      p1_ge2  <= (y >= RW'(2));
      p1_res  <= res_valid;
      p1_last <= last;
      // same entry written back this cycle: take the new value
      p1_fwd      <= p1_valid && (p1_x == x);
      p1_fwd_data <= wr_data;
      p1_known    <= WW'(x) < fill;
    end
    if (p1_valid) begin
      out_item.win  <= ev;
      out_item.last <= p1_last;
    end
  end

  assign busy = p1_valid;

endmodule

`default_nettype wire

@@ sv/snc_classify.sv @@
// Hit-or-miss matching of the 3x3 window over eight rotations, registered label.
`timescale 1ns / 1ps
`default_nettype none

module snc_classify (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           output_mode,
  input  logic                 in_valid,
  input  snc_pkg::win_item_t   in_item,
  output logic                 out_valid,
  output snc_pkg::label_item_t out_item
);
  import snc_pkg::*;

  function automatic logic [7:0] rot8(input logic [7:0] v, input logic [2:0] s);
    logic [15:0] d;
    d = {v, v} << s;
    return d[15:8];
  endfunction

  function automatic logic all_of(input logic [7:0] v, input logic [7:0] m);
    return (v & m) == m;
  endfunction

  function automatic logic none_of(input logic [7:0] v, input logic [7:0] m);
    return (v & m) == 8'd0;
  endfunction

  function automatic logic [2:0] rank_plain(input logic ctr, input logic [7:0] nb);
    logic [7:0] r;
    logic [3:0] cnt;
    logic       found;
    logic [2:0] res;
    cnt   = 4'($countones(nb));
    found = 1'b0;
    res   = LBL_NONE;
    if (!ctr) begin
      res = all_of(nb, NB_PLUS) ? LBL_HOLLOW : LBL_NONE;
    end else if (cnt <= 4'd1) begin
      res = LBL_END;
    end else begin
      for (int s = 0; s < 8; s++) begin
        r = rot8(nb, 3'(s));
        if (!found) begin
          if (all_of(r, NB_TOP) && none_of(r, NB_LOW5)) begin
            res   = LBL_END;
            found = 1'b1;
          end else if (all_of(r, NB_FORK) && (none_of(r, NB_X1) || none_of(r, NB_X2))) begin
            res   = LBL_J3;
            found = 1'b1;
          end else if (all_of(r, NB_T) && none_of(r, NB_TGAP)) begin
            res   = LBL_J3;
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        if (cnt <= 4'd3) begin
          res = LBL_BRANCH;
        end else if ((all_of(nb, NB_DIAG) && none_of(nb, NB_PLUS)) ||
                     (all_of(nb, NB_PLUS) && none_of(nb, NB_DIAG)) ||
                     all_of(nb, NB_SQUARE)) begin
          res = LBL_J4;
        end else begin
          res = LBL_BRANCH;
        end
      end
    end
    return res;
  endfunction

  function automatic logic [2:0] rank_debug(input logic ctr, input logic [7:0] nb);
    logic [7:0] r;
    logic       found;
    logic [2:0] res;
    found = 1'b0;
    res   = LBL_NONE;
    if (!ctr) begin
      res = all_of(nb, NB_PLUS) ? LBL_HOLLOW : LBL_NONE;
    end else if (nb == 8'd0) begin
      res = LBL_END;
    end else begin
      for (int s = 0; s < 8; s++) begin
        r = rot8(nb, 3'(s));
        if (!found) begin
          if (all_of(r, NB_TOP) && none_of(r, NB_LOW5)) begin
            res   = LBL_END;
            found = 1'b1;
          end else if (all_of(r, NB_FORK) && none_of(r, NB_X1)) begin
            res   = LBL_J3;
            found = 1'b1;
          end else if (all_of(r, NB_FORK) && none_of(r, NB_ALT)) begin
            res   = LBL_J3_ALT;
            found = 1'b1;
          end else if (all_of(r, NB_T) && none_of(r, NB_TGAP)) begin
            res   = LBL_J3;
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        if ((all_of(nb, NB_DIAG) && none_of(nb, NB_PLUS)) ||
            (all_of(nb, NB_PLUS) && none_of(nb, NB_DIAG))) begin
          res = LBL_J4;
        end else if (all_of(nb, NB_SQUARE)) begin
          res = LBL_SQUARE;
        end else begin
          res = LBL_BRANCH;
        end
      end
    end
    return res;
  endfunction

  logic [2:0] lf, cc, rt;
  logic [7:0] nb;
  logic       ctr;
  logic [2:0] rp, rd, role, label;

  always_comb begin
    lf  = in_item.win[2:0];
    cc  = in_item.win[5:3];
    rt  = in_item.win[8:6];
    ctr = cc[1];
    nb  = {lf[0], cc[0], rt[0], rt[1], rt[2], cc[2], lf[2], lf[1]};
    rp  = rank_plain(ctr, nb);
    rd  = rank_debug(ctr, nb);
    if (rp == LBL_END) begin
      role = ROLE_END;
    end else if (rp == LBL_BRANCH) begin
      role = ROLE_BRANCH;
    end else if (rp == LBL_NONE) begin
      role = ROLE_BG;
    end else begin
      role = ROLE_NODE;
    end
    unique case (output_mode)
      MODE_DEBUG: label = rd;
      MODE_ROLE:  label = role;
      default:    label = rp;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      out_item.label <= label;
      out_item.last  <= in_item.last;
    end
  end

endmodule

`default_nettype wire

@@ sv/snc_out_fifo.sv @@
// Small result queue between the classifier and the output stream.
`timescale 1ns / 1ps
`default_nettype none

module snc_out_fifo (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  snc_pkg::label_item_t     wr_item,
  output logic [snc_pkg::OUT_CW-1:0] count,
  output logic                     rd_valid,
  input  logic                     rd_ready,
  output snc_pkg::label_item_t     rd_item
);
  import snc_pkg::*;

  label_item_t       slots [OUT_DEPTH];
  logic [OUT_AW-1:0] wr_ptr, rd_ptr;
  logic              rd_en;

  assign rd_valid = (count != '0);
  assign rd_en    = rd_valid && rd_ready;
  assign rd_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == OUT_AW'(OUT_DEPTH - 1)) ? '0 : wr_ptr + OUT_AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == OUT_AW'(OUT_DEPTH - 1)) ? '0 : rd_ptr + OUT_AW'(1);
      end
      count <= count + OUT_CW'(wr_en) - OUT_CW'(rd_en);
    end
  end

endmodule

`default_nettype wire

@@ sv/skeleton_node_classifier_3x3_core.sv @@
// Top level of the skeleton node classifier: config registers, window, classifier, output queue.
//
// Usage:
//   Slave stream carries one skeleton pixel per transfer in raster order (tdata[0] pixel,
//   tuser[0] flush). After each frame send image_width+1 transfers with flush set to drain.
//   Master stream carries one label per frame pixel in raster order; tlast marks the
//   frame's final pixel. Flush transfers before a frame starts are dropped.
//   Config port: cfg_wr_en with cfg_index 0 width, 1 height, 2 output mode (0 rank,
//   1 role, 2 debug rank). Write only while the block is idle.
//   Throughput: one transfer per clock in and out while m_tready stays high; a pixel's
//   label leaves with the input transfer image_width+1 positions later.
//   A label becomes valid on the master side once the input transfer that completes its
//   window has passed the registers at line memory read, window, match and queue.
//   Backpressure: an 8-entry result queue absorbs a stalled receiver; s_tready drops
//   once queue content plus in-flight results reach its depth, with no path from m_tready.
//   Reset: registers return to width 512, height 512, mode 0, position and window clear.
//   The line memory needs no clearing; rows above the frame are masked and entries not
//   written since reset read as zero.
`timescale 1ns / 1ps
`default_nettype none

module skeleton_node_classifier_3x3_core #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] pixel, [7:1] zero
  input  logic [0:0]  s_tuser,   // [0] flush
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [2:0] label, [7:3] zero
  output logic        m_tlast
);
  import snc_pkg::*;

  logic [CFG_W-1:0] image_width, image_height;
  logic [1:0]       output_mode;

  logic             in_acc;
  logic             lw_busy, lw_valid, cls_valid;
  win_item_t        lw_item;
  label_item_t      cls_item, q_item;
  logic [OUT_CW-1:0] q_count, pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 12'd512;
      image_height <= 12'd512;
      output_mode  <= MODE_RANK;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        CFG_OUTPUT_MODE:  output_mode  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // room in the queue for everything already in flight
  assign pending  = q_count + OUT_CW'(lw_busy) + OUT_CW'(lw_valid) + OUT_CW'(cls_valid);
  assign s_tready = pending < OUT_CW'(OUT_DEPTH);
  assign in_acc   = s_tvalid && s_tready;

  snc_line_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_window (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .in_valid     (in_acc),
    .pixel        (s_tdata[0]),
    .flush        (s_tuser[0]),
    .busy         (lw_busy),
    .out_valid    (lw_valid),
    .out_item     (lw_item)
  );

  snc_classify u_classify (
    .clk         (clk),
    .rst         (rst),
    .output_mode (output_mode),
    .in_valid    (lw_valid),
    .in_item     (lw_item),
    .out_valid   (cls_valid),
    .out_item    (cls_item)
  );

  snc_out_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cls_valid),
    .wr_item  (cls_item),
    .count    (q_count),
    .rd_valid (m_tvalid),
    .rd_ready (m_tready),
    .rd_item  (q_item)
  );

  assign m_tdata = {5'd0, q_item.label};
  assign m_tlast = q_item.last;

endmodule

`default_nettype wire

@@ dv/skeleton_node_classifier_3x3_core_tb.sv @@
// Self-checking testbench for the 3x3 skeleton node classifier core.
`timescale 1ns / 1ps

module skeleton_node_classifier_3x3_core_tb;
  import snc_pkg::*;

  localparam int LINE_MAX    = 2048;
  localparam int HEIGHT_MAX  = 2048;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 8;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [0] pixel, [7:1] zero
  logic [0:0]  s_tuser = '0;   // [0] flush
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [2:0] label, [7:3] zero
  logic        m_tlast;

  logic        hold_on = 1'b0;
  int          src_idle_pct = 0;
  int          snk_stall_pct = 0;
  int          err_cnt = 0;
  int          in_cnt = 0;
  int          out_cnt = 0;
  int          frame_cnt = 0;
  int          quiet_cycles = 0;
  int          dens_tab [5] = '{8, 25, 50, 75, 95};

  // predictor copy of registers and pipeline position
  logic [11:0] pred_width = 12'd512;
  logic [11:0] pred_height = 12'd512;
  logic [1:0]  pred_mode = MODE_RANK;
  logic [1:0]  line_mem [LINE_MAX];
  logic [8:0]  win_reg = '0;
  logic [10:0] col_pos = '0;
  logic [11:0] row_pos = '0;
  label_item_t label_q [$];

  always #10 clk = ~clk;

  skeleton_node_classifier_3x3_core #(
    .MAX_WIDTH(LINE_MAX),
    .MAX_HEIGHT(HEIGHT_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  initial begin
    foreach (line_mem[i]) line_mem[i] = 2'b00;
  end

  function automatic int eff_dim(logic [11:0] v, int lim);
    if (v == 0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  function automatic logic [7:0] rotl8(logic [7:0] v, int s);
    logic [15:0] d;
    d = {v, v} << s;
    return d[15:8];
  endfunction

  function automatic bit all_set(logic [7:0] v, logic [7:0] m);
    return (v & m) == m;
  endfunction

  function automatic bit none_set(logic [7:0] v, logic [7:0] m);
    return (v & m) == 8'h00;
  endfunction

  function automatic logic [2:0] plain_rank(logic ctr, logic [7:0] nb);
    logic [7:0] r;
    int ones;
    int s;
    if (!ctr) return all_set(nb, NB_PLUS) ? LBL_HOLLOW : LBL_NONE;
    ones = $countones(nb);
    if (ones <= 1) return LBL_END;
    for (s = 0; s < 8; s++) begin
      r = rotl8(nb, s);
      if (all_set(r, NB_TOP) && none_set(r, NB_LOW5)) return LBL_END;
      if (all_set(r, NB_FORK) && (none_set(r, NB_X1) || none_set(r, NB_X2))) return LBL_J3;
      if (all_set(r, NB_T) && none_set(r, NB_TGAP)) return LBL_J3;
    end
    if (ones <= 3) return LBL_BRANCH;
    if ((all_set(nb, NB_DIAG) && none_set(nb, NB_PLUS)) ||
        (all_set(nb, NB_PLUS) && none_set(nb, NB_DIAG)) || all_set(nb, NB_SQUARE))
      return LBL_J4;
    return LBL_BRANCH;
  endfunction

  function automatic logic [2:0] debug_rank(logic ctr, logic [7:0] nb);
    logic [7:0] r;
    int s;
    if (!ctr) return all_set(nb, NB_PLUS) ? LBL_HOLLOW : LBL_NONE;
    if (nb == 8'h00) return LBL_END;
    for (s = 0; s < 8; s++) begin
      r = rotl8(nb, s);
      if (all_set(r, NB_TOP) && none_set(r, NB_LOW5)) return LBL_END;
      if (all_set(r, NB_FORK)) begin
        if (none_set(r, NB_X1)) return LBL_J3;
        if (none_set(r, NB_ALT)) return LBL_J3_ALT;
      end
      if (all_set(r, NB_T) && none_set(r, NB_TGAP)) return LBL_J3;
    end
    if ((all_set(nb, NB_DIAG) && none_set(nb, NB_PLUS)) ||
        (all_set(nb, NB_PLUS) && none_set(nb, NB_DIAG)))
      return LBL_J4;
    if (all_set(nb, NB_SQUARE)) return LBL_SQUARE;
    return LBL_BRANCH;
  endfunction

  // window columns: [2:0] left, [5:3] center, [8:6] right; bit0 of each is the top row
  function automatic logic [2:0] window_label(logic [8:0] win);
    logic [2:0] lf, cc, rt, r;
    logic [7:0] nb;
    lf = win[2:0];
    cc = win[5:3];
    rt = win[8:6];
    nb = {lf[0], cc[0], rt[0], rt[1], rt[2], cc[2], lf[2], lf[1]};
    if (pred_mode == MODE_DEBUG) return debug_rank(cc[1], nb);
    r = plain_rank(cc[1], nb);
    if (pred_mode == MODE_ROLE) begin
      case (r)
        LBL_NONE:   return ROLE_BG;
        LBL_END:    return ROLE_END;
        LBL_BRANCH: return ROLE_BRANCH;
        default:    return ROLE_NODE;
      endcase
    end
    return r;
  endfunction

  // advance the window by one accepted pixel and queue the label it completes, if any
  function automatic void track_pixel(logic px, logic fl);
    int w, h, x, y;
    logic v, mid, top, hit, fin;
    logic [1:0] line;
    logic [2:0] cnew;
    logic [8:0] ev;
    label_item_t e;
    w = eff_dim(pred_width, LINE_MAX);
    h = eff_dim(pred_height, HEIGHT_MAX);
    if (col_pos == 0 && row_pos == 0 && fl) return;
    if (int'(col_pos) >= w) begin
      col_pos = '0;
      row_pos = row_pos + 12'd1;
    end
    x = int'(col_pos);
    y = int'(row_pos);
    v = px && !fl && (y < h);
    line = line_mem[x];
    mid = (y >= 1) ? line[0] : 1'b0;
    top = (y >= 2) ? line[1] : 1'b0;
    cnew = {v, mid, top};
    line_mem[x] = {line[0], v};
    if (x == 0) begin
      // row wrap: the pending right-edge column closes with zero padding
      ev = win_reg >> 3;
      win_reg = {cnew, 6'b0};
      hit = (y >= 2) && (y <= h + 1);
      fin = (y == h + 1);
    end else begin
      win_reg = {cnew, win_reg[8:3]};
      ev = win_reg;
      hit = (y >= 1) && (y <= h);
      fin = 1'b0;
    end
    if (y >= h + 1) begin
      col_pos = '0;
      row_pos = '0;
    end else if (x + 1 >= w) begin
      col_pos = '0;
      row_pos = 12'(y + 1);
    end else begin
      col_pos = 11'(x + 1);
    end
    if (hit) begin
      e.label = window_label(ev);
      e.last = fin;
      label_q = {label_q, e};
    end
  endfunction

  function automatic void note_fail(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("MISMATCH: %s", msg);
  endfunction

  task automatic send_pixel(input logic px, input logic fl);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, px};
    s_tuser  <= fl;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    in_cnt++;
    track_pixel(px, fl);
  endtask

  // stop offering and wait until every queued label has come back
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (label_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_IMAGE_WIDTH:  pred_width = val;
      CFG_IMAGE_HEIGHT: pred_height = val;
      CFG_OUTPUT_MODE:  pred_mode = val[1:0];
      default: ;
    endcase
  endtask

  task automatic set_frame(input logic [11:0] w, input logic [11:0] h, input logic [1:0] mode);
    wait_quiet();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_OUTPUT_MODE, {10'b0, mode});
  endtask

  // flush until the position returns to the start of a frame
  task automatic finish_frame();
    while (col_pos != 0 || row_pos != 0) send_pixel(1'b0, 1'b1);
  endtask

  task automatic send_frame(input int fw, input int fh, input int dens, input bit noisy);
    int n_drain;
    int i;
    if (noisy && $urandom_range(5) == 0) send_pixel(1'($urandom_range(1)), 1'b1);
    for (i = 0; i < fw * fh; i++) begin
      if (noisy && $urandom_range(29) == 0) send_pixel(1'($urandom_range(1)), 1'b1);
      else send_pixel($urandom_range(99) < dens, 1'b0);
    end
    n_drain = fw + 1;
    if (noisy && $urandom_range(7) == 0) n_drain = $urandom_range(fw);
    for (i = 0; i < n_drain; i++) begin
      if (noisy && $urandom_range(9) == 0) send_pixel(1'($urandom_range(1)), 1'b0);
      else send_pixel(1'($urandom_range(1)), 1'b1);
    end
  endtask

  task automatic test_idle_flush();
    // still at reset defaults: flushes with no frame begun are dropped
    send_pixel(1'b1, 1'b1);
    send_pixel(1'b0, 1'b1);
    set_frame(12'd1, 12'd1, MODE_RANK);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b0, 1'b1);
    send_pixel(1'b1, 1'b1);
    set_frame(12'd1, 12'd1, MODE_SPARE);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b1, 1'b1);
    send_pixel(1'b0, 1'b1);
  endtask

  task automatic test_flush_in_frame();
    set_frame(12'd2, 12'd2, MODE_ROLE);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b1, 1'b1);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b1, 1'b0);
    // foreground offered during drain still reads as zero
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b0, 1'b1);
    send_pixel(1'b1, 1'b1);
  endtask

  task automatic test_width_shrink();
    set_frame(12'd3, 12'd3, MODE_DEBUG);
    repeat (4) send_pixel(1'b1, 1'b0);
    wait_quiet();
    write_reg(CFG_IMAGE_WIDTH, 12'd1);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b1, 1'b0);
    finish_frame();
  endtask

  task automatic test_height_shrink();
    set_frame(12'd2, 12'd3, MODE_RANK);
    repeat (6) send_pixel(1'b1, 1'b0);
    wait_quiet();
    write_reg(CFG_IMAGE_HEIGHT, 12'd1);
    // past the shortened frame: no label, position back to zero
    send_pixel(1'b1, 1'b0);
    finish_frame();
    send_frame(2, 1, 50, 1'b0);
  endtask

  task automatic test_large_frames();
    src_idle_pct = 11;
    snk_stall_pct = 11;
    // zero height reads as one row, zero width as one column
    set_frame(12'd120, 12'h000, MODE_DEBUG);
    send_frame(120, 1, 50, 1'b0);
    set_frame(12'h000, 12'd60, MODE_ROLE);
    send_frame(1, 60, 50, 1'b0);
    src_idle_pct = 0;
    snk_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    set_frame(12'd8, 12'd8, MODE_RANK);
    hold_on <= 1'b1;
    fork
      begin
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none
    send_frame(8, 8, 60, 1'b0);
    // sender pauses until the output side has caught up completely
    wait_quiet();
    send_frame(8, 8, 40, 1'b0);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n_items);
    int start;
    logic [11:0] w;
    src_idle_pct = idle_pct;
    snk_stall_pct = stall_pct;
    start = in_cnt;
    while (in_cnt - start < n_items) begin
      if ($urandom_range(1) == 0) begin
        finish_frame();
        w = ($urandom_range(9) == 0) ? 12'd0 : 12'($urandom_range(12, 1));
        set_frame(w, 12'($urandom_range(8, 1)), 2'($urandom_range(3)));
      end
      send_frame(eff_dim(pred_width, LINE_MAX), eff_dim(pred_height, HEIGHT_MAX),
                 dens_tab[$urandom_range(4)], 1'b1);
    end
    finish_frame();
  endtask

  always @(posedge clk) begin : label_sink
    label_item_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (label_q.size() == 0) begin
          note_fail($sformatf("unexpected label tdata %0h tlast %0b", m_tdata, m_tlast));
        end else begin
          want = label_q.pop_front();
          if (m_tdata !== {5'b0, want.label})
            note_fail($sformatf("label %0d: expected %0d, got %0h", out_cnt, want.label, m_tdata));
          if (m_tlast !== want.last)
            note_fail($sformatf("label %0d: expected tlast %0b, got %0b", out_cnt, want.last,
                                m_tlast));
          out_cnt++;
          if (want.last) frame_cnt++;
        end
      end
      m_tready <= !hold_on && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("skeleton_node_classifier_3x3_core verification failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_flush();
    test_flush_in_frame();
    test_width_shrink();
    test_height_shrink();
    test_large_frames();
    test_backpressure();
    test_random_phase(0, 0, 170);
    test_random_phase(47, 0, 170);
    test_random_phase(0, 47, 170);
    test_random_phase(11, 11, 170);
    wait_quiet();
    $display("covered %0d input transfers, %0d labels checked over %0d frames, %0d mismatches",
             in_cnt, out_cnt, frame_cnt, err_cnt);
    $display("all output modes, zero-size clamping, mid-frame resize, stalls and hold-off");
    if (err_cnt == 0) begin
      $display("skeleton_node_classifier_3x3_core verification clean");
    end else begin
      $display("skeleton_node_classifier_3x3_core verification failed");
    end
    $finish;
  end

endmodule
